@@ hw/rtl/ieu_pkg.sv @@
// Package for the integer execute unit: command, status and flag codes.
// Depends on nothing; used by ieu_seq_unit, the top level and the simulation files.
package ieu_pkg;
	typedef enum logic [3:0] {
		CMD_MOV = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_JMP = 4'd3,
		CMD_JNE = 4'd4, CMD_INC = 4'd5, CMD_CMP = 4'd6, CMD_INT = 4'd7,
		CMD_MUL = 4'd8, CMD_DEC = 4'd9, CMD_DIV = 4'd10, CMD_AND = 4'd11,
		CMD_OR = 4'd12, CMD_XOR = 4'd13, CMD_NOT = 4'd14, CMD_NOP = 4'd15
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_BAD_COUNT = 3'd1, ST_BAD_TYPE = 3'd2,
		ST_DIV_ZERO = 3'd3, ST_DIV_OVF = 3'd4, ST_BAD_SYSCALL = 3'd5
	} status_t;

	typedef struct packed {
		logic zf;
		logic sf;
		logic cf;
		logic of;
	} flags_t;

	typedef enum logic {
		SEQ_MUL = 1'b0,
		SEQ_DIV = 1'b1
	} seq_op_t;

	typedef struct packed {
		logic start;
		seq_op_t op;
	} seq_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} seq_sts_t;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [7:0] SYSCALL_VEC = 8'h80;
	localparam int ITER = 32;
endpackage

@@ hw/rtl/ieu_seq_unit.sv @@
// Shift-and-add multiplier and restoring divider sharing one 33-bit adder.
// Depends on ieu_pkg; one bit per cycle, 32 iterations.
module ieu_seq_unit (
	input  logic clk,
	input  logic arst_n,
	input  ieu_pkg::seq_ctl_t ctl,
	input  logic [31:0] hi,
	input  logic [31:0] lo,
	input  logic [31:0] opnd,
	output ieu_pkg::seq_sts_t sts,
	output logic [31:0] res_hi,
	output logic [31:0] res_lo
);
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] opnd_q;
	logic [5:0] cnt_q;
	logic busy_q;
	ieu_pkg::seq_op_t op_q;
	logic [32:0] add_a;
	logic [32:0] add_b;
	logic [32:0] add_y;
	logic do_sub;

	always_comb begin
		do_sub = (op_q == ieu_pkg::SEQ_DIV);
		if (do_sub) begin
			add_a = {hi_q, lo_q[31]};
			add_b = ~{1'b0, opnd_q};
		end else begin
			add_a = {1'b0, hi_q};
			add_b = lo_q[0] ? {1'b0, opnd_q} : 33'd0;
		end
		add_y = add_a + add_b + {32'd0, do_sub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			op_q <= ieu_pkg::SEQ_MUL;
			sts <= '0;
			hi_q <= '0;
			lo_q <= '0;
			opnd_q <= '0;
		end else begin
			sts.done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= ctl.op;
				hi_q <= (ctl.op == ieu_pkg::SEQ_MUL) ? 32'd0 : hi;
				lo_q <= lo;
				opnd_q <= opnd;
				sts.ovf <= (ctl.op == ieu_pkg::SEQ_DIV) && (hi >= opnd);
			end else if (busy_q) begin
				if (do_sub) begin
					// Restoring step: the remainder keeps its top bit in the carry.
					if (hi_q[31] || !add_y[32]) begin
						hi_q <= add_y[31:0];
						lo_q <= {lo_q[30:0], 1'b1};
					end else begin
						hi_q <= {hi_q[30:0], lo_q[31]};
						lo_q <= {lo_q[30:0], 1'b0};
					end
				end else begin
					hi_q <= add_y[32:1];
					lo_q <= {add_y[0], lo_q[31:1]};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(ieu_pkg::ITER - 1)) begin
					busy_q <= 1'b0;
					sts.done <= 1'b1;
				end
			end
		end
	end

	assign res_hi = hi_q;
	assign res_lo = lo_q;
endmodule

@@ hw/rtl/integer_execute_unit_32.sv @@
// Top level of the integer execute unit: decode, register file, flags, sequencer.
// Depends on ieu_pkg and ieu_seq_unit.
//
// channel | dir | contents
// s_axis  | in  | one decoded instruction per beat
// m_axis  | out | one result per beat
//
// Single-cycle instructions pass from the accepted beat through S_EXEC to S_OUT.
// MUL and DIV with a non-zero divisor go through S_EXEC and S_WAIT, with 32 steps of the shared adder, to S_OUT.
// arst_n clears the register file, flags and control state.
// A waiting result blocks the next beat until m_axis_tready takes it.
module integer_execute_unit_32 #(
	parameter int NUM_REGS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[3:0], operand_count[5:4], dest_reg[8:6], dest_is_reg[9],
	// src_reg[12:10], src_is_reg[13], imm_value[45:14], zero fill[47:46]
	input  logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status[2:0], jump_taken[3], jump_target[35:4], exited[36],
	// exit_value[68:37], result_value[100:69], zero_flag[101], sign_flag[102],
	// carry_flag[103], overflow_flag[104], zero fill[111:105]
	output logic [111:0] m_axis_tdata
);
	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} state_t;

	state_t state_q;
	logic [31:0] rf_q [NUM_REGS];
	ieu_pkg::flags_t fl_q;
	logic [47:0] ins_q;
	logic [2:0] st_q;
	logic jt_q;
	logic [31:0] tgt_q;
	logic ex_q;
	logic [31:0] code_q;
	logic [31:0] res_q;
	ieu_pkg::seq_ctl_t ctl;
	ieu_pkg::seq_sts_t sts;
	logic [31:0] seq_hi;
	logic [31:0] seq_lo;

	ieu_pkg::cmd_t cmd;
	logic [1:0] cnt;
	logic [2:0] dr;
	logic dreg;
	logic [2:0] sr;
	logic sreg;
	logic [31:0] imm;
	logic two, one, dr_ok, sr_ok;
	logic [31:0] a, b, eax, ebx, edx, r;
	logic [32:0] sum;

	always_comb begin
		cmd = ieu_pkg::cmd_t'(ins_q[3:0]);
		cnt = ins_q[5:4];
		dr = ins_q[8:6];
		dreg = ins_q[9];
		sr = ins_q[12:10];
		sreg = ins_q[13];
		imm = ins_q[45:14];
		two = (cmd == ieu_pkg::CMD_MOV) || (cmd == ieu_pkg::CMD_ADD) ||
			(cmd == ieu_pkg::CMD_SUB) || (cmd == ieu_pkg::CMD_CMP) ||
			(cmd == ieu_pkg::CMD_AND) || (cmd == ieu_pkg::CMD_OR) ||
			(cmd == ieu_pkg::CMD_XOR);
		one = (cmd == ieu_pkg::CMD_MUL) || (cmd == ieu_pkg::CMD_DIV) ||
			(cmd == ieu_pkg::CMD_NOT);
		dr_ok = 32'(dr) < NUM_REGS;
		sr_ok = 32'(sr) < NUM_REGS;
		a = dr_ok ? rf_q[RW'(dr)] : 32'd0;
		b = two ? (sreg ? (sr_ok ? rf_q[RW'(sr)] : 32'd0) : imm) : 32'd0;
		eax = rf_q[0];
		edx = (NUM_REGS > 2) ? rf_q[2 % NUM_REGS] : 32'd0;
		ebx = (NUM_REGS > 3) ? rf_q[3 % NUM_REGS] : 32'd0;
		sum = {1'b0, a} + {1'b0, ((cmd == ieu_pkg::CMD_ADD) ? b : ~b)} +
			{32'd0, cmd != ieu_pkg::CMD_ADD};
		r = sum[31:0];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {7'd0, fl_q.of, fl_q.cf, fl_q.sf, fl_q.zf, res_q, code_q, ex_q,
		tgt_q, jt_q, st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fl_q <= '0;
			ctl <= '0;
			ins_q <= '0;
			st_q <= '0;
			jt_q <= 1'b0;
			tgt_q <= '0;
			ex_q <= 1'b0;
			code_q <= '0;
			res_q <= '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			ctl.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						ins_q <= s_axis_tdata;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= ieu_pkg::ST_OK;
					jt_q <= 1'b0;
					tgt_q <= '0;
					ex_q <= 1'b0;
					code_q <= '0;
					res_q <= '0;
					state_q <= S_OUT;
					if (cmd == ieu_pkg::CMD_NOP) begin
					end else if ((two && cnt != 2'd2) || (one && cnt != 2'd1) || cnt == 2'd0) begin
						st_q <= ieu_pkg::ST_BAD_COUNT;
					end else if (cmd == ieu_pkg::CMD_JMP) begin
						if (dreg) st_q <= ieu_pkg::ST_BAD_TYPE;
						else begin
							jt_q <= 1'b1;
							tgt_q <= imm;
						end
					end else if (cmd == ieu_pkg::CMD_JNE) begin
						if (!fl_q.zf) begin
							jt_q <= 1'b1;
							tgt_q <= imm;
						end
					end else if (cmd == ieu_pkg::CMD_INT) begin
						if (dreg) st_q <= ieu_pkg::ST_BAD_TYPE;
						else if (imm[7:0] == ieu_pkg::SYSCALL_VEC) begin
							if (eax == 32'd1) begin
								ex_q <= 1'b1;
								code_q <= ebx;
							end else st_q <= ieu_pkg::ST_BAD_SYSCALL;
						end
					end else if (!dreg || !dr_ok) begin
						st_q <= ieu_pkg::ST_BAD_TYPE;
					end else if (two && ((cmd == ieu_pkg::CMD_ADD && !sreg) || (sreg && !sr_ok))) begin
						st_q <= ieu_pkg::ST_BAD_TYPE;
					end else begin
						case (cmd)
							ieu_pkg::CMD_MOV: begin
								res_q <= b;
								rf_q[RW'(dr)] <= b;
							end
							ieu_pkg::CMD_ADD: begin
								fl_q <= '{zf: r == 0, sf: r[31], cf: sum[32],
									of: (a[31] == b[31]) && (a[31] != r[31])};
								res_q <= r;
								rf_q[RW'(dr)] <= r;
							end
							ieu_pkg::CMD_SUB, ieu_pkg::CMD_CMP: begin
								fl_q <= '{zf: r == 0, sf: r[31], cf: a < b,
									of: (a[31] != b[31]) && (b[31] == r[31])};
								if (cmd == ieu_pkg::CMD_SUB) begin
									res_q <= r;
									rf_q[RW'(dr)] <= r;
								end
							end
							ieu_pkg::CMD_INC, ieu_pkg::CMD_DEC: begin
								logic [31:0] t;
								t = (cmd == ieu_pkg::CMD_INC) ? a + 32'd1 : a - 32'd1;
								fl_q.zf <= t == 0;
								fl_q.sf <= t[31];
								fl_q.of <= a == ((cmd == ieu_pkg::CMD_INC) ?
									ieu_pkg::INT_MAX : ieu_pkg::INT_MIN);
								res_q <= t;
								rf_q[RW'(dr)] <= t;
							end
							ieu_pkg::CMD_MUL: begin
								ctl <= '{start: 1'b1, op: ieu_pkg::SEQ_MUL};
								state_q <= S_WAIT;
							end
							ieu_pkg::CMD_DIV: begin
								if (a == 0) st_q <= ieu_pkg::ST_DIV_ZERO;
								else begin
									ctl <= '{start: 1'b1, op: ieu_pkg::SEQ_DIV};
									state_q <= S_WAIT;
								end
							end
							ieu_pkg::CMD_AND, ieu_pkg::CMD_OR, ieu_pkg::CMD_XOR: begin
								logic [31:0] l;
								l = (cmd == ieu_pkg::CMD_AND) ? (a & b) :
									(cmd == ieu_pkg::CMD_OR) ? (a | b) : (a ^ b);
								fl_q <= '{zf: l == 0, sf: l[31], cf: 1'b0, of: 1'b0};
								res_q <= l;
								rf_q[RW'(dr)] <= l;
							end
							default: begin
								res_q <= ~a;
								rf_q[RW'(dr)] <= ~a;
							end
						endcase
					end
				end
				S_WAIT: begin
					if (sts.done) begin
						state_q <= S_OUT;
						if (ctl.op == ieu_pkg::SEQ_MUL) begin
							res_q <= seq_lo;
							rf_q[0] <= seq_lo;
							if (NUM_REGS > 2) rf_q[2 % NUM_REGS] <= seq_hi;
							fl_q.cf <= seq_hi != 0;
							fl_q.of <= seq_hi != 0;
						end else if (sts.ovf) begin
							st_q <= ieu_pkg::ST_DIV_OVF;
						end else begin
							res_q <= seq_lo;
							rf_q[0] <= seq_lo;
							if (NUM_REGS > 2) rf_q[2 % NUM_REGS] <= seq_hi;
						end
					end
				end
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ieu_seq_unit u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.hi(edx),
		.lo(eax),
		.opnd(a),
		.sts(sts),
		.res_hi(seq_hi),
		.res_lo(seq_lo)
	);
endmodule

@@ hw/rtl/ieu_checker.sv @@
// Port checker for the integer execute unit, bound to the top level.
// Depends on integer_execute_unit_32 port names only.
module ieu_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [111:0] m_axis_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
		else $error("accept not followed by busy");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5) else $error("bad status");
endmodule

bind integer_execute_unit_32 ieu_checker u_chk (.*);

@@ sim/ieu_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the integer execute unit: predicts each result beat from the
// accepted instruction beats and compares it field by field. Depends on ieu_pkg.
module ieu_result_checker
	import ieu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [47:0] in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [111:0] out_data,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [2:0] status;
		logic jt;
		logic [31:0] target;
		logic ex;
		logic [31:0] code;
		logic [31:0] res;
		flags_t fl;
	} outcome_t;

	logic [31:0] regs [8];
	flags_t flags;
	outcome_t awaited [$];

	function automatic flags_t zs(logic [31:0] r);
		flags_t f;
		f = '0;
		f.zf = (r == 0);
		f.sf = r[31];
		return f;
	endfunction

	task automatic execute_instruction(logic [47:0] d);
		cmd_t cmd;
		logic [1:0] cnt;
		logic [2:0] dr, sr;
		logic dreg, sreg, two, one;
		logic [31:0] imm, a, b, r;
		logic [63:0] wide, quo;
		outcome_t o;
		cmd = cmd_t'(d[3:0]);
		cnt = d[5:4];
		dr = d[8:6];
		dreg = d[9];
		sr = d[12:10];
		sreg = d[13];
		imm = d[45:14];
		o = '0;
		two = cmd inside {CMD_MOV, CMD_ADD, CMD_SUB, CMD_CMP, CMD_AND, CMD_OR, CMD_XOR};
		one = cmd inside {CMD_MUL, CMD_DIV, CMD_NOT};
		if (cmd == CMD_NOP) begin
		end else if ((two && cnt != 2) || (one && cnt != 1) || cnt == 0) begin
			o.status = ST_BAD_COUNT;
		end else if (cmd == CMD_JMP) begin
			if (dreg) o.status = ST_BAD_TYPE;
			else begin
				o.jt = 1'b1;
				o.target = imm;
			end
		end else if (cmd == CMD_JNE) begin
			if (!flags.zf) begin
				o.jt = 1'b1;
				o.target = imm;
			end
		end else if (cmd == CMD_INT) begin
			if (dreg) o.status = ST_BAD_TYPE;
			else if (imm[7:0] == SYSCALL_VEC) begin
				if (regs[0] == 1) begin
					o.ex = 1'b1;
					o.code = regs[3];
				end else o.status = ST_BAD_SYSCALL;
			end
		end else if (!dreg || (two && cmd == CMD_ADD && !sreg)) begin
			o.status = ST_BAD_TYPE;
		end else begin
			a = regs[dr];
			b = two ? (sreg ? regs[sr] : imm) : 32'd0;
			case (cmd)
				CMD_MOV: begin
					o.res = b;
					regs[dr] = b;
				end
				CMD_ADD: begin
					r = a + b;
					flags = zs(r);
					flags.cf = r < a;
					flags.of = (a[31] == b[31]) && (a[31] != r[31]);
					o.res = r;
					regs[dr] = r;
				end
				CMD_SUB, CMD_CMP: begin
					r = a - b;
					flags = zs(r);
					flags.cf = a < b;
					flags.of = (a[31] != b[31]) && (b[31] == r[31]);
					if (cmd == CMD_SUB) begin
						o.res = r;
						regs[dr] = r;
					end
				end
				CMD_INC, CMD_DEC: begin
					r = (cmd == CMD_INC) ? a + 32'd1 : a - 32'd1;
					flags = '{zf: r == 0, sf: r[31], cf: flags.cf,
						of: a == ((cmd == CMD_INC) ? INT_MAX : INT_MIN)};
					o.res = r;
					regs[dr] = r;
				end
				CMD_MUL: begin
					wide = 64'(regs[0]) * 64'(a);
					regs[0] = wide[31:0];
					regs[2] = wide[63:32];
					flags.cf = wide[63:32] != 0;
					flags.of = flags.cf;
					o.res = wide[31:0];
				end
				CMD_DIV: begin
					if (a == 0) o.status = ST_DIV_ZERO;
					else begin
						wide = {regs[2], regs[0]};
						quo = wide / 64'(a);
						if (quo[63:32] != 0) o.status = ST_DIV_OVF;
						else begin
							o.res = quo[31:0];
							regs[0] = quo[31:0];
							regs[2] = 32'(wide % 64'(a));
						end
					end
				end
				CMD_AND, CMD_OR, CMD_XOR: begin
					r = (cmd == CMD_AND) ? (a & b) : (cmd == CMD_OR) ? (a | b) : (a ^ b);
					flags = zs(r);
					o.res = r;
					regs[dr] = r;
				end
				default: begin
					o.res = ~a;
					regs[dr] = ~a;
				end
			endcase
		end
		o.fl = flags;
		awaited.push_back(o);
	endtask

	task automatic compare_field(string name, logic [31:0] exp, logic [31:0] got);
		if (exp !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t e, g;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			flags = '0;
			awaited.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready) execute_instruction(in_data);
			if (out_valid && out_ready) begin
				g = {out_data[2:0], out_data[3], out_data[35:4], out_data[36],
					out_data[68:37], out_data[100:69], out_data[101], out_data[102],
					out_data[103], out_data[104]};
				if (awaited.size() == 0) begin
					$error("result beat with no instruction outstanding");
					fail_count++;
				end else begin
					e = awaited.pop_front();
					compare_field("status", 32'(e.status), 32'(g.status));
					compare_field("jump_taken", 32'(e.jt), 32'(g.jt));
					compare_field("jump_target", e.target, g.target);
					compare_field("exited", 32'(e.ex), 32'(g.ex));
					compare_field("exit_value", e.code, g.code);
					compare_field("result_value", e.res, g.res);
					compare_field("zero_flag", 32'(e.fl.zf), 32'(g.fl.zf));
					compare_field("sign_flag", 32'(e.fl.sf), 32'(g.fl.sf));
					compare_field("carry_flag", 32'(e.fl.cf), 32'(g.fl.cf));
					compare_field("overflow_flag", 32'(e.fl.of), 32'(g.fl.of));
				end
			end
			pending = awaited.size();
		end
	end
endmodule

@@ sim/tb_integer_execute_unit_32.sv @@
`timescale 1ns / 100ps
// Testbench top for the integer execute unit: drives directed and random instruction
// beats with random idling and a long output hold-off. Depends on ieu_pkg, the unit and the checker.
module tb_integer_execute_unit_32;
	import ieu_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [111:0] m_axis_tdata;
	int fail_count, pending;
	int send_idle = 21, recv_idle = 59;
	bit hold_off = 0;

	integer_execute_unit_32 dut (.*);

	ieu_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	task automatic send_instruction(cmd_t cmd, int cnt, int dr, int dreg,
			int sr, int sreg, logic [31:0] imm);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {2'b00, imm, 1'(sreg), 3'(sr), 1'(dreg), 3'(dr), 2'(cnt), cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return INT_MIN;
			3: return INT_MAX;
			4: return $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random();
		cmd_t cmd;
		int cnt;
		cmd = cmd_t'($urandom_range(15));
		if ($urandom_range(9) == 0) cnt = $urandom_range(3);
		else if (cmd inside {CMD_MOV, CMD_ADD, CMD_SUB, CMD_CMP, CMD_AND, CMD_OR, CMD_XOR})
			cnt = 2;
		else if (cmd inside {CMD_MUL, CMD_DIV, CMD_NOT}) cnt = 1;
		else cnt = $urandom_range(1, 3);
		if (cmd == CMD_INT && $urandom_range(1))
			send_instruction(cmd, cnt, $urandom, int'($urandom_range(9) == 0), $urandom,
				$urandom, {16'($urandom_range(16'hFFFF)), $urandom_range(1) ? 8'h00 : 8'hFF,
				SYSCALL_VEC});
		else
			send_instruction(cmd, cnt, $urandom, (cmd inside {CMD_JMP, CMD_INT}) ?
				int'($urandom_range(9) == 0) : int'($urandom_range(9) != 0), $urandom,
				int'($urandom_range(3) != 0), random_value());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_instruction(CMD_MOV, 2, 0, 1, 0, 0, 32'hFFFF_FFFF);
		send_instruction(CMD_MOV, 2, 1, 1, 0, 0, 32'd1);
		send_instruction(CMD_ADD, 2, 0, 1, 1, 1, 0);
		send_instruction(CMD_ADD, 2, 0, 1, 1, 0, 0);
		send_instruction(CMD_MOV, 2, 3, 1, 0, 0, INT_MAX);
		send_instruction(CMD_INC, 1, 3, 1, 0, 0, 0);
		send_instruction(CMD_DEC, 1, 3, 1, 0, 0, 0);
		send_instruction(CMD_SUB, 2, 1, 1, 0, 0, INT_MIN);
		send_instruction(CMD_CMP, 2, 1, 1, 1, 1, 0);
		send_instruction(CMD_JNE, 1, 0, 0, 0, 0, 32'h1234);
		send_instruction(CMD_JMP, 1, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_instruction(CMD_JMP, 1, 0, 1, 0, 0, 0);
		send_instruction(CMD_MOV, 2, 0, 1, 0, 0, 32'hFFFF_FFFF);
		send_instruction(CMD_MUL, 1, 0, 1, 0, 0, 0);
		send_instruction(CMD_DIV, 1, 4, 1, 0, 0, 0);
		send_instruction(CMD_DIV, 1, 1, 1, 0, 0, 0);
		send_instruction(CMD_MOV, 2, 5, 1, 0, 0, 32'h7);
		send_instruction(CMD_DIV, 1, 5, 1, 0, 0, 0);
		send_instruction(CMD_AND, 2, 0, 1, 0, 0, 32'hF0F0_F0F0);
		send_instruction(CMD_OR, 2, 1, 1, 0, 1, 0);
		send_instruction(CMD_XOR, 2, 1, 1, 1, 1, 0);
		send_instruction(CMD_NOT, 1, 7, 1, 0, 0, 0);
		send_instruction(CMD_INT, 1, 0, 0, 0, 0, 32'h80);
		send_instruction(CMD_MOV, 2, 0, 1, 0, 0, 32'd1);
		send_instruction(CMD_INT, 1, 0, 0, 0, 0, 32'hFFFF_FF80);
		send_instruction(CMD_NOP, 0, 7, 1, 7, 1, 32'hFFFF_FFFF);
		send_instruction(CMD_MOV, 0, 0, 1, 0, 0, 0);
		for (int i = 0; i < 850; i++) begin
			if (i == 280) begin
				send_idle = 59;
				recv_idle = 21;
			end
			if (i == 560) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_random();
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (2000) @(posedge clk);
		hold_off <= 1;
		repeat (400) @(posedge clk);
		hold_off <= 0;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
